/* rtl/pshl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pshl_pkg
// Shared types and constants for the priority-sorted handle list.
// ----------------------------------------------------------------------------
package pshl_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int HANDLE_W = 6;
  localparam int PTR_W    = 7;
  localparam int KEY_W    = 32;
  localparam int HALF_W   = 16;
  localparam logic [PTR_W-1:0] NIL = 7'd64;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_CHG  = 2'd2,
    CMD_LIST = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POOL_EMPTY = 2'd1,
    ST_NOT_IN_USE = 2'd2,
    ST_LIST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                command;
    logic [HANDLE_W-1:0] handle;
    logic [HALF_W-1:0]   bg_priority;
    logic [HALF_W-1:0]   oam_priority;
  } in_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] result_handle;
    status_t             status;
    logic                last;
  } out_item_t;

  // datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_RES_POOL,
    OP_RES_BAD,
    OP_RES_EMPTY,
    OP_FS_RD,
    OP_ALLOC,
    OP_KEY_RD,
    OP_KEY_SET,
    OP_KEY_WR,
    OP_LI_HEAD,
    OP_LI_START,
    OP_P_RD,
    OP_LI_ADV,
    OP_LI_BEF1,
    OP_LI_BEF2,
    OP_LI_END1,
    OP_LI_END2,
    OP_LO_RD,
    OP_LO_W1,
    OP_LO_W2,
    OP_FREE,
    OP_EMIT,
    OP_LS_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic pool_empty;
    logic handle_ok;
    logic head_nil;
    logic key_less;
    logic next_nil;
    logic out_free;
  } sts_t;

endpackage

/* rtl/priority_sorted_handle_list.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_sorted_handle_list
// Handle pool with a key-sorted doubly linked list, sequencer plus datapath.
// ----------------------------------------------------------------------------
// One command at a time. Add and change search the insert point by walking
// the list from the head, one linked-list memory read per visited entry;
// list reads each entry and then emits its handle, waiting while the output
// is stalled. Results sit in an output register, so a new command is
// taken while the last result of the previous one is still waiting.
// ----------------------------------------------------------------------------
module priority_sorted_handle_list (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pshl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pshl_pkg::out_item_t out_data
);
  import pshl_pkg::*;

  ctl_t ctl;
  sts_t sts;

  pshl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .ctl(ctl)
  );

  pshl_dp u_dp (
    .clk(clk), .rst(rst), .in_data(in_data), .ctl(ctl), .sts(sts),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

/* rtl/pshl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pshl_ram
// Generic single-write, single-read RAM with registered read and read enable.
// ----------------------------------------------------------------------------
module pshl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/pshl_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pshl_dp
// Datapath: link, key and free-stack memories, pointers and result register.
// ----------------------------------------------------------------------------
module pshl_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  pshl_pkg::in_item_t   in_data,
  input  pshl_pkg::ctl_t       ctl,
  output pshl_pkg::sts_t       sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pshl_pkg::out_item_t  out_data
);
  import pshl_pkg::*;

  cmd_t                cmd;
  logic [HANDLE_W-1:0] h;
  logic [HALF_W-1:0]   oam;
  logic [KEY_W-1:0]    key;
  logic [PTR_W-1:0]    p;
  logic [PTR_W-1:0]    sp;
  logic [PTR_W-1:0]    head;
  status_t             st;
  logic [CAPACITY-1:0] in_use;
  logic [CAPACITY-1:0] nvld, pvld, fvld;
  logic                nvld_q, pvld_q, fvld_q;
  logic [IDX_W-1:0]    fs_ra_q;

  logic             key_we, key_re, nxt_we, nxt_re, prv_we, prv_re, fs_we, fs_re;
  logic [IDX_W-1:0] key_wa, key_ra, nxt_wa, nxt_ra, prv_wa, prv_ra, fs_wa, fs_ra;
  logic [KEY_W-1:0] key_wd, key_q;
  logic [PTR_W-1:0] nxt_wd, nxt_q, prv_wd, prv_q;
  logic [HANDLE_W-1:0] fs_wd, fs_q;

  logic [PTR_W-1:0]    next_eff, prev_eff, h7;
  logic [HANDLE_W-1:0] fs_h;
  logic [IDX_W-1:0]    hi, pi;
  logic [PTR_W-1:0]    sp_dec;
  logic                out_free;

  // entries never written read as their reset value
  assign next_eff = nvld_q ? nxt_q : NIL;
  assign prev_eff = pvld_q ? prv_q : NIL;
  assign fs_h     = fvld_q ? fs_q : HANDLE_W'(fs_ra_q);
  assign h7       = {1'b0, h};
  assign hi       = h[IDX_W-1:0];
  assign pi       = p[IDX_W-1:0];
  assign sp_dec   = sp - PTR_W'(1);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    sts.cmd        = cmd;
    sts.pool_empty = (sp >= PTR_W'(CAPACITY));
    sts.handle_ok  = (h7 < PTR_W'(CAPACITY)) && in_use[hi] && (sp != '0);
    sts.head_nil   = (head == NIL);
    sts.key_less   = (key < key_q);
    sts.next_nil   = (next_eff == NIL);
    sts.out_free   = out_free;
  end

  always_comb begin
    key_we = 1'b0; key_wa = '0; key_wd = key; key_re = 1'b0; key_ra = '0;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = NIL; nxt_re = 1'b0; nxt_ra = '0;
    prv_we = 1'b0; prv_wa = '0; prv_wd = NIL; prv_re = 1'b0; prv_ra = '0;
    fs_we  = 1'b0; fs_wa  = '0; fs_wd  = h;   fs_re  = 1'b0; fs_ra  = '0;
    case (ctl.op)
      OP_FS_RD: begin
        fs_re = 1'b1; fs_ra = sp[IDX_W-1:0];
      end
      OP_ALLOC: begin
        key_we = 1'b1; key_wa = fs_h[IDX_W-1:0];
      end
      OP_KEY_RD: begin
        key_re = 1'b1; key_ra = hi;
      end
      OP_KEY_WR: begin
        key_we = 1'b1; key_wa = hi;
      end
      OP_LI_HEAD, OP_LO_W2: begin
        nxt_we = 1'b1; nxt_wa = hi;
        prv_we = 1'b1; prv_wa = hi;
      end
      OP_P_RD: begin
        key_re = 1'b1; key_ra = pi;
        nxt_re = 1'b1; nxt_ra = pi;
        prv_re = 1'b1; prv_ra = pi;
      end
      OP_LI_BEF1: begin
        prv_we = 1'b1; prv_wa = hi; prv_wd = prev_eff;
        nxt_we = 1'b1; nxt_wa = hi; nxt_wd = p;
      end
      OP_LI_BEF2: begin
        prv_we = 1'b1; prv_wa = pi; prv_wd = h7;
        nxt_we = (prev_eff != NIL); nxt_wa = prev_eff[IDX_W-1:0]; nxt_wd = h7;
      end
      OP_LI_END1: begin
        nxt_we = 1'b1; nxt_wa = pi; nxt_wd = h7;
        prv_we = 1'b1; prv_wa = hi; prv_wd = p;
      end
      OP_LI_END2: begin
        nxt_we = 1'b1; nxt_wa = hi;
      end
      OP_LO_RD: begin
        nxt_re = 1'b1; nxt_ra = hi;
        prv_re = 1'b1; prv_ra = hi;
      end
      OP_LO_W1: begin
        nxt_we = (prev_eff != NIL); nxt_wa = prev_eff[IDX_W-1:0]; nxt_wd = next_eff;
        prv_we = (next_eff != NIL); prv_wa = next_eff[IDX_W-1:0]; prv_wd = prev_eff;
      end
      OP_FREE: begin
        fs_we = 1'b1; fs_wa = sp_dec[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  pshl_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_wd),
    .re(key_re), .raddr(key_ra), .rdata(key_q)
  );
  pshl_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_nxt_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
    .re(nxt_re), .raddr(nxt_ra), .rdata(nxt_q)
  );
  pshl_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_prv_ram (
    .clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
    .re(prv_re), .raddr(prv_ra), .rdata(prv_q)
  );
  pshl_ram #(.WIDTH(HANDLE_W), .DEPTH(CAPACITY)) u_fs_ram (
    .clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd),
    .re(fs_re), .raddr(fs_ra), .rdata(fs_q)
  );

  // written flags for the memories with a defined reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      nvld <= '0;
      pvld <= '0;
      fvld <= '0;
    end else begin
      if (nxt_we) nvld[nxt_wa] <= 1'b1;
      if (prv_we) pvld[prv_wa] <= 1'b1;
      if (fs_we)  fvld[fs_wa]  <= 1'b1;
    end
    if (nxt_re) nvld_q <= nvld[nxt_ra];
    if (prv_re) pvld_q <= pvld[prv_ra];
    if (fs_re) begin
      fvld_q  <= fvld[fs_ra];
      fs_ra_q <= fs_ra;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp        <= '0;
      head      <= NIL;
      in_use    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.op == OP_EMIT || ctl.op == OP_LS_EMIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (ctl.op)
        OP_ALLOC: begin
          sp <= sp + PTR_W'(1);
          in_use[fs_h[IDX_W-1:0]] <= 1'b1;
        end
        OP_LI_HEAD: head <= h7;
        OP_LI_BEF1: if (p == head) head <= h7;
        OP_LO_W1:   if (prev_eff == NIL) head <= next_eff;
        OP_FREE: begin
          sp <= sp_dec;
          in_use[hi] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_ACCEPT: begin
        cmd <= in_data.command;
        h   <= in_data.handle;
        oam <= in_data.oam_priority;
        key <= {in_data.bg_priority, in_data.oam_priority};
        st  <= ST_OK;
      end
      OP_RES_POOL: begin
        h  <= '0;
        st <= ST_POOL_EMPTY;
      end
      OP_RES_BAD: st <= ST_NOT_IN_USE;
      OP_RES_EMPTY: begin
        h  <= '0;
        st <= ST_LIST_EMPTY;
      end
      OP_ALLOC:    h   <= fs_h;
      OP_KEY_SET:  key <= {key_q[KEY_W-1:HALF_W], oam};
      OP_LI_START: p   <= head;
      OP_LI_ADV:   p   <= next_eff;
      OP_EMIT: begin
        out_data.result_handle <= h;
        out_data.status        <= st;
        out_data.last          <= 1'b1;
      end
      OP_LS_EMIT: begin
        out_data.result_handle <= p[HANDLE_W-1:0];
        out_data.status        <= ST_OK;
        out_data.last          <= (next_eff == NIL);
        p                      <= next_eff;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/pshl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pshl_ctrl
// Sequencer: walks each command through datapath micro-operations.
// ----------------------------------------------------------------------------
module pshl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  pshl_pkg::sts_t sts,
  output pshl_pkg::ctl_t ctl
);
  import pshl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_ADD_RD, S_ADD_ALLOC, S_LI_CHK, S_LI_RD, S_LI_CMP,
    S_LI_BEF2, S_LI_END2, S_LO_RD, S_LO_W1, S_LO_W2, S_DEL_FREE,
    S_CH_KRD, S_CH_KSET, S_CH_KWR, S_EMIT, S_LS_RD, S_LS_EMIT
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl.op     = OP_NONE;
    case (state)
      S_IDLE: if (in_valid) begin
        ctl.op = OP_ACCEPT; state_next = S_DISP;
      end
      S_DISP: begin
        case (sts.cmd)
          CMD_ADD: begin
            if (sts.pool_empty) begin
              ctl.op = OP_RES_POOL; state_next = S_EMIT;
            end else begin
              ctl.op = OP_FS_RD; state_next = S_ADD_ALLOC;
            end
          end
          CMD_DEL, CMD_CHG: begin
            if (!sts.handle_ok) begin
              ctl.op = OP_RES_BAD; state_next = S_EMIT;
            end else if (sts.cmd == CMD_DEL) begin
              state_next = S_LO_RD;
            end else begin
              state_next = S_CH_KRD;
            end
          end
          default: begin
            if (sts.head_nil) begin
              ctl.op = OP_RES_EMPTY; state_next = S_EMIT;
            end else begin
              ctl.op = OP_LI_START; state_next = S_LS_RD;
            end
          end
        endcase
      end
      S_ADD_RD:    state_next = S_ADD_ALLOC;
      S_ADD_ALLOC: begin
        ctl.op = OP_ALLOC; state_next = S_LI_CHK;
      end
      S_LI_CHK: begin
        if (sts.head_nil) begin
          ctl.op = OP_LI_HEAD; state_next = S_EMIT;
        end else begin
          ctl.op = OP_LI_START; state_next = S_LI_RD;
        end
      end
      S_LI_RD: begin
        ctl.op = OP_P_RD; state_next = S_LI_CMP;
      end
      S_LI_CMP: begin
        // insert before the first strictly larger key, else append at tail
        if (sts.key_less) begin
          ctl.op = OP_LI_BEF1; state_next = S_LI_BEF2;
        end else if (sts.next_nil) begin
          ctl.op = OP_LI_END1; state_next = S_LI_END2;
        end else begin
          ctl.op = OP_LI_ADV; state_next = S_LI_RD;
        end
      end
      S_LI_BEF2: begin
        ctl.op = OP_LI_BEF2; state_next = S_EMIT;
      end
      S_LI_END2: begin
        ctl.op = OP_LI_END2; state_next = S_EMIT;
      end
      S_LO_RD: begin
        ctl.op = OP_LO_RD; state_next = S_LO_W1;
      end
      S_LO_W1: begin
        ctl.op = OP_LO_W1; state_next = S_LO_W2;
      end
      S_LO_W2: begin
        ctl.op = OP_LO_W2;
        state_next = (sts.cmd == CMD_DEL) ? S_DEL_FREE : S_CH_KWR;
      end
      S_DEL_FREE: begin
        ctl.op = OP_FREE; state_next = S_EMIT;
      end
      S_CH_KRD: begin
        ctl.op = OP_KEY_RD; state_next = S_CH_KSET;
      end
      S_CH_KSET: begin
        ctl.op = OP_KEY_SET; state_next = S_LO_RD;
      end
      S_CH_KWR: begin
        ctl.op = OP_KEY_WR; state_next = S_LI_CHK;
      end
      S_EMIT: if (sts.out_free) begin
        ctl.op = OP_EMIT; state_next = S_IDLE;
      end
      S_LS_RD: begin
        ctl.op = OP_P_RD; state_next = S_LS_EMIT;
      end
      S_LS_EMIT: if (sts.out_free) begin
        ctl.op = OP_LS_EMIT;
        state_next = sts.next_nil ? S_IDLE : S_LS_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/pshl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pshl_checker
// Port-level checks for the priority-sorted handle list.
// ----------------------------------------------------------------------------
module pshl_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input pshl_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input pshl_pkg::out_item_t out_data
);
  import pshl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> $stable(in_data))
    else $error("stalled input payload changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.last)
    else $error("error result not marked last");

  a_err_handle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_POOL_EMPTY ||
                  out_data.status == ST_LIST_EMPTY) |-> out_data.result_handle == '0)
    else $error("empty result carries a handle");

endmodule

bind priority_sorted_handle_list pshl_checker u_pshl_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);
